// ===== sv/pemu_pkg.sv =====
// Shared types, constants and helper functions for the particle emitter update core.
`default_nettype none
package pemu_pkg;

  localparam int DEFAULT_PARTICLE_COUNT = 1024;
  localparam int TABLE_DEPTH = 1024;

  localparam logic [23:0] AGE_MAX  = 24'hFFFFFF;
  localparam logic [23:0] LIFETIME = 24'd327680;
  localparam logic [30:0] Q30_ONE  = 31'h40000000;
  localparam logic [30:0] X_SCALE  = 31'd1686629713;
  localparam logic [16:0] SIDE_COEF = 17'd29309;
  localparam logic [16:0] UP_COEF   = 17'd58618;
  localparam logic [15:0] QUARTER   = 16'd16384;

  // register indexes
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] CFG_GRAVITY_X = 3'd3;
  localparam logic [2:0] CFG_GRAVITY_Y = 3'd4;
  localparam logic [2:0] CFG_GRAVITY_Z = 3'd5;
  localparam logic [2:0] CFG_SPEED     = 3'd6;
  localparam logic [2:0] CFG_TIME_STEP = 3'd7;

  localparam logic [30:0] SPEED_RESET = 31'd65536;
  localparam logic [15:0] STEP_RESET  = 16'd1092;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SPAWN  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [9:0] particle_index;
    logic       slice_start;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         result_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               respawned;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [23:0]        age;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_READ, CMD_FETCH, CMD_MUL, CMD_ACC, CMD_PHASE,
    CMD_QMUL, CMD_X, CMD_XX, CMD_X2, CMD_HMUL, CMD_DSTART, CMD_DWAIT,
    CMD_TUPD, CMD_SMUL, CMD_S, CMD_CMUL, CMD_SV, CMD_WB
  } cmd_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_FETCH, S_UMUL, S_UACC, S_PHASE, S_QMUL, S_X, S_XX, S_X2,
    S_HMUL, S_DSTART, S_DWAIT, S_TUPD, S_SMUL, S_S, S_CMUL, S_SV, S_VMUL,
    S_VACC, S_WB
  } state_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [3:0] k;    // lane: 0-2 position, 3-5 gravity, 6-8 launch velocity
    logic [2:0] j;    // series term
    logic       sel;  // 0 cosine angle, 1 sine angle
  } cmd_t;

  typedef struct packed {
    logic respawn;
    logic div_busy;
    logic out_free;
  } status_t;

  // divisors of the sine series, highest term first
  function automatic logic [6:0] series_div(input logic [2:0] j);
    logic [6:0] d;
    unique case (j)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [49:0] s;
    s = 50'(a) + 50'(b);
    return sat32(s);
  endfunction

endpackage
`default_nettype wire

// ===== sv/pemu_div.sv =====
// Constant divider for the sine series terms: reciprocal multiplication, then add and shift.
`default_nettype none
module pemu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [6:0]  divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  // reciprocal m = ceil(2^k / d) with k = 32 + ceil(log2 d); m lies in [2^32, 2^33),
  // so only the low 32 bits are kept and the 2^32 part is added back as a shift
  localparam logic [31:0] RCP_110 = 32'(((64'd1 << 39) + 64'd109) / 64'd110);
  localparam logic [31:0] RCP_72  = 32'(((64'd1 << 39) + 64'd71) / 64'd72);
  localparam logic [31:0] RCP_42  = 32'(((64'd1 << 38) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP_20  = 32'(((64'd1 << 37) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP_6   = 32'(((64'd1 << 35) + 64'd5) / 64'd6);

  logic [31:0] rcp_sel;
  logic [5:0]  sh_sel;
  logic [31:0] dvd;
  logic [31:0] rcp;
  logic [5:0]  sh;
  logic [63:0] prod;
  logic        stage;
  logic [64:0] sum;

  always_comb begin
    unique case (divisor)
      7'd110: begin
        rcp_sel = RCP_110;
        sh_sel  = 6'd39;
      end
      7'd72: begin
        rcp_sel = RCP_72;
        sh_sel  = 6'd39;
      end
      7'd42: begin
        rcp_sel = RCP_42;
        sh_sel  = 6'd38;
      end
      7'd20: begin
        rcp_sel = RCP_20;
        sh_sel  = 6'd37;
      end
      default: begin
        rcp_sel = RCP_6;
        sh_sel  = 6'd35;
      end
    endcase
  end

  assign sum = {1'b0, dvd, 32'b0} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      stage <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      stage <= 1'b0;
    end else if (busy) begin
      if (!stage) stage <= 1'b1;
      else busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rcp <= rcp_sel;
      sh  <= sh_sel;
    end
    if (busy && !stage) prod <= dvd * rcp;
    if (busy && stage) quotient <= 32'(sum >> sh);
  end
endmodule
`default_nettype wire

// ===== sv/pemu_ctrl.sv =====
// Sequencer that steps the datapath through an update or a respawn.
`default_nettype none
module pemu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pemu_pkg::status_t status,
  output pemu_pkg::cmd_t        cmd
);
  pemu_pkg::state_t state, state_next;
  logic [3:0] k, k_next;
  logic [2:0] j, j_next;
  logic       sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pemu_pkg::S_IDLE;
      k     <= '0;
      j     <= '0;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      sel   <= sel_next;
    end
  end

  assign in_stall = state != pemu_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    sel_next   = sel;
    cmd.op     = pemu_pkg::CMD_NONE;
    cmd.k      = k;
    cmd.j      = j;
    cmd.sel    = sel;
    unique case (state)
      pemu_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = pemu_pkg::CMD_LOAD;
          state_next = pemu_pkg::S_RD;
        end
      end
      pemu_pkg::S_RD: begin
        cmd.op     = pemu_pkg::CMD_READ;
        state_next = pemu_pkg::S_FETCH;
      end
      pemu_pkg::S_FETCH: begin
        cmd.op = pemu_pkg::CMD_FETCH;
        if (status.respawn) begin
          state_next = pemu_pkg::S_PHASE;
        end else begin
          k_next     = 4'd0;
          state_next = pemu_pkg::S_UMUL;
        end
      end
      pemu_pkg::S_UMUL: begin
        cmd.op     = pemu_pkg::CMD_MUL;
        state_next = pemu_pkg::S_UACC;
      end
      pemu_pkg::S_UACC: begin
        cmd.op = pemu_pkg::CMD_ACC;
        if (k == 4'd5) begin
          state_next = pemu_pkg::S_WB;
        end else begin
          k_next     = k + 4'd1;
          state_next = pemu_pkg::S_UMUL;
        end
      end
      pemu_pkg::S_PHASE: begin
        cmd.op     = pemu_pkg::CMD_PHASE;
        sel_next   = 1'b0;
        state_next = pemu_pkg::S_QMUL;
      end
      pemu_pkg::S_QMUL: begin
        cmd.op     = pemu_pkg::CMD_QMUL;
        state_next = pemu_pkg::S_X;
      end
      pemu_pkg::S_X: begin
        cmd.op     = pemu_pkg::CMD_X;
        state_next = pemu_pkg::S_XX;
      end
      pemu_pkg::S_XX: begin
        cmd.op     = pemu_pkg::CMD_XX;
        state_next = pemu_pkg::S_X2;
      end
      pemu_pkg::S_X2: begin
        cmd.op     = pemu_pkg::CMD_X2;
        j_next     = 3'd0;
        state_next = pemu_pkg::S_HMUL;
      end
      pemu_pkg::S_HMUL: begin
        cmd.op     = pemu_pkg::CMD_HMUL;
        state_next = pemu_pkg::S_DSTART;
      end
      pemu_pkg::S_DSTART: begin
        cmd.op     = pemu_pkg::CMD_DSTART;
        state_next = pemu_pkg::S_DWAIT;
      end
      pemu_pkg::S_DWAIT: begin
        cmd.op = pemu_pkg::CMD_DWAIT;
        if (!status.div_busy) state_next = pemu_pkg::S_TUPD;
      end
      pemu_pkg::S_TUPD: begin
        cmd.op = pemu_pkg::CMD_TUPD;
        if (j == 3'd4) begin
          state_next = pemu_pkg::S_SMUL;
        end else begin
          j_next     = j + 3'd1;
          state_next = pemu_pkg::S_HMUL;
        end
      end
      pemu_pkg::S_SMUL: begin
        cmd.op     = pemu_pkg::CMD_SMUL;
        state_next = pemu_pkg::S_S;
      end
      pemu_pkg::S_S: begin
        cmd.op     = pemu_pkg::CMD_S;
        state_next = pemu_pkg::S_CMUL;
      end
      pemu_pkg::S_CMUL: begin
        cmd.op     = pemu_pkg::CMD_CMUL;
        state_next = pemu_pkg::S_SV;
      end
      pemu_pkg::S_SV: begin
        cmd.op = pemu_pkg::CMD_SV;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = pemu_pkg::S_QMUL;
        end else begin
          k_next     = 4'd6;
          state_next = pemu_pkg::S_VMUL;
        end
      end
      pemu_pkg::S_VMUL: begin
        cmd.op     = pemu_pkg::CMD_MUL;
        state_next = pemu_pkg::S_VACC;
      end
      pemu_pkg::S_VACC: begin
        cmd.op = pemu_pkg::CMD_ACC;
        if (k == 4'd8) begin
          state_next = pemu_pkg::S_WB;
        end else begin
          k_next     = k + 4'd1;
          state_next = pemu_pkg::S_VMUL;
        end
      end
      pemu_pkg::S_WB: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.op     = pemu_pkg::CMD_WB;
          state_next = pemu_pkg::S_IDLE;
        end
      end
      default: state_next = pemu_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/pemu_dp.sv =====
// Datapath: particle table, config registers, shared multiplier and result register.
`default_nettype none
module pemu_dp #(
  parameter int PARTICLE_COUNT = pemu_pkg::DEFAULT_PARTICLE_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_addr,
  input  wire logic [31:0]        cfg_wdata,
  input  wire pemu_pkg::in_word_t in_word,
  input  wire pemu_pkg::cmd_t     cmd,
  output pemu_pkg::status_t       status,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pemu_pkg::out_word_t     out_word
);
  localparam int PHASE_STEP = 65536 / PARTICLE_COUNT;
  localparam logic [15:0] PHASE_INC = 16'(PHASE_STEP);

  // config
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic signed [31:0] gravity_x, gravity_y, gravity_z;
  logic [30:0] launch_speed;
  logic [15:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      gravity_x    <= '0;
      gravity_y    <= '0;
      gravity_z    <= '0;
      launch_speed <= pemu_pkg::SPEED_RESET;
      time_step    <= pemu_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pemu_pkg::CFG_ORIGIN_X:  origin_x     <= cfg_wdata;
        pemu_pkg::CFG_ORIGIN_Y:  origin_y     <= cfg_wdata;
        pemu_pkg::CFG_ORIGIN_Z:  origin_z     <= cfg_wdata;
        pemu_pkg::CFG_GRAVITY_X: gravity_x    <= cfg_wdata;
        pemu_pkg::CFG_GRAVITY_Y: gravity_y    <= cfg_wdata;
        pemu_pkg::CFG_GRAVITY_Z: gravity_z    <= cfg_wdata;
        pemu_pkg::CFG_SPEED:     launch_speed <= cfg_wdata[30:0];
        pemu_pkg::CFG_TIME_STEP: time_step    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // particle table
  pemu_pkg::entry_t mem [pemu_pkg::TABLE_DEPTH];
  pemu_pkg::entry_t rdata;

  // working registers
  logic [9:0]  idx;
  logic        opcode;
  logic        respawn;
  logic [15:0] phase;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic [23:0] age;
  logic signed [65:0] prod;
  logic [30:0] x;
  logic [31:0] x2;
  logic [30:0] t;
  logic [30:0] s;
  logic        neg;
  logic signed [16:0] side_c, side_s;

  // item-level combinational values
  logic [24:0] age_sum;
  logic [23:0] age_new;
  logic        resp_now;

  assign age_sum  = 25'(rdata.age) + 25'(time_step);
  assign age_new  = (age_sum > 25'(pemu_pkg::AGE_MAX)) ? pemu_pkg::AGE_MAX : age_sum[23:0];
  assign resp_now = (opcode == pemu_pkg::OP_SPAWN) || (age_new > pemu_pkg::LIFETIME);

  // quarter-wave reduction of the selected angle
  logic [15:0] ang;
  logic [14:0] qang;
  assign ang  = cmd.sel ? phase : phase + pemu_pkg::QUARTER;
  assign qang = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pemu_pkg::CMD_MUL: begin
        mul_b = {17'b0, time_step};
        unique case (cmd.k)
          4'd0: mul_a = 33'(vel_x);
          4'd1: mul_a = 33'(vel_y);
          4'd2: mul_a = 33'(vel_z);
          4'd3: mul_a = 33'(gravity_x);
          4'd4: mul_a = 33'(gravity_y);
          4'd5: mul_a = 33'(gravity_z);
          4'd6: begin
            mul_a = {2'b0, launch_speed};
            mul_b = 33'(side_c);
          end
          4'd7: begin
            mul_a = {2'b0, launch_speed};
            mul_b = {16'b0, pemu_pkg::UP_COEF};
          end
          default: begin
            mul_a = {2'b0, launch_speed};
            mul_b = -33'(side_s);
          end
        endcase
      end
      pemu_pkg::CMD_QMUL: begin
        mul_a = {18'b0, qang};
        mul_b = {2'b0, pemu_pkg::X_SCALE};
      end
      pemu_pkg::CMD_XX: begin
        mul_a = {2'b0, x};
        mul_b = {2'b0, x};
      end
      pemu_pkg::CMD_HMUL: begin
        mul_a = {1'b0, x2};
        mul_b = {2'b0, t};
      end
      pemu_pkg::CMD_SMUL: begin
        mul_a = {2'b0, x};
        mul_b = {2'b0, t};
      end
      pemu_pkg::CMD_CMUL: begin
        mul_a = {2'b0, s};
        mul_b = {16'b0, pemu_pkg::SIDE_COEF};
      end
      default: ;
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  // Q16.16 product rounded half up, then saturated
  logic signed [65:0] rnd;
  logic signed [31:0] prod_q;
  assign rnd    = (prod + 66'sd32768) >>> 16;
  assign prod_q = pemu_pkg::sat32(rnd[49:0]);

  logic [65:0] s_shift;
  logic [65:0] sv_shift;
  logic [14:0] sv;
  assign s_shift  = 66'(prod) >> 30;
  assign sv_shift = 66'(prod + 66'sd536870912) >> 30;
  assign sv       = sv_shift[14:0];

  // divider for the series terms
  logic [31:0] quot;
  logic        div_busy;

  pemu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == pemu_pkg::CMD_DSTART),
    .dividend (prod[61:30]),
    .divisor  (pemu_pkg::series_div(cmd.j)),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == pemu_pkg::CMD_READ) rdata <= mem[idx];
    if (cmd.op == pemu_pkg::CMD_WB) mem[idx] <= '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.op == pemu_pkg::CMD_LOAD && in_word.slice_start) begin
      phase <= 16'(32'(in_word.particle_index) * 32'(PHASE_STEP));
    end else if (cmd.op == pemu_pkg::CMD_PHASE) begin
      phase <= phase + PHASE_INC;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pemu_pkg::CMD_MUL || cmd.op == pemu_pkg::CMD_QMUL ||
        cmd.op == pemu_pkg::CMD_XX || cmd.op == pemu_pkg::CMD_HMUL ||
        cmd.op == pemu_pkg::CMD_SMUL || cmd.op == pemu_pkg::CMD_CMUL) begin
      prod <= mul_p;
    end
    unique case (cmd.op)
      pemu_pkg::CMD_LOAD: begin
        idx    <= in_word.particle_index;
        opcode <= in_word.opcode;
      end
      pemu_pkg::CMD_FETCH: begin
        pos_x   <= rdata.pos_x;
        pos_y   <= rdata.pos_y;
        pos_z   <= rdata.pos_z;
        vel_x   <= rdata.vel_x;
        vel_y   <= rdata.vel_y;
        vel_z   <= rdata.vel_z;
        age     <= age_new;
        respawn <= resp_now;
      end
      pemu_pkg::CMD_ACC: begin
        unique case (cmd.k)
          4'd0: pos_x <= pemu_pkg::add_sat(pos_x, prod_q);
          4'd1: pos_y <= pemu_pkg::add_sat(pos_y, prod_q);
          4'd2: pos_z <= pemu_pkg::add_sat(pos_z, prod_q);
          4'd3: vel_x <= pemu_pkg::add_sat(vel_x, prod_q);
          4'd4: vel_y <= pemu_pkg::add_sat(vel_y, prod_q);
          4'd5: vel_z <= pemu_pkg::add_sat(vel_z, prod_q);
          4'd6: vel_x <= prod_q;
          4'd7: vel_y <= prod_q;
          default: vel_z <= prod_q;
        endcase
      end
      pemu_pkg::CMD_PHASE: begin
        age   <= '0;
        pos_x <= origin_x;
        pos_y <= origin_y;
        pos_z <= origin_z;
      end
      pemu_pkg::CMD_QMUL: neg <= ang[15];
      pemu_pkg::CMD_X: x <= 31'((prod + 66'sd8192) >>> 14);
      pemu_pkg::CMD_X2: begin
        x2 <= prod[61:30];
        t  <= pemu_pkg::Q30_ONE;
      end
      pemu_pkg::CMD_TUPD: t <= 31'(32'(pemu_pkg::Q30_ONE) - quot);
      pemu_pkg::CMD_S: s <= (s_shift > 66'(pemu_pkg::Q30_ONE)) ? pemu_pkg::Q30_ONE
                                                               : s_shift[30:0];
      pemu_pkg::CMD_SV: begin
        if (cmd.sel) side_s <= neg ? -17'(sv) : 17'(sv);
        else side_c <= neg ? -17'(sv) : 17'(sv);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == pemu_pkg::CMD_WB) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pemu_pkg::CMD_WB) begin
      out_word <= '{idx, pos_x, pos_y, pos_z, respawn};
    end
  end

  assign status.respawn  = resp_now;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || !out_stall;
endmodule
`default_nettype wire

// ===== sv/particle_emitter_update_core.sv =====
// Particle emitter update core: top level joining the sequencer and the datapath.
// One word in gives one word out. An update runs from acceptance until the next
// word can be taken through accept, table read, fetch, six multiply/accumulate
// pairs on the one shared multiplier and write-back. A spawn or a respawn runs
// through the sine series instead: two angles, each with setup steps, five terms
// with a reciprocal-multiply division each and finishing steps, then three
// velocity multiply/accumulate pairs. Items are handled one at a time; a finished
// word waits in the output register while the next item is taken, and write-back
// stalls while that register still holds an unaccepted word. The particle table
// holds no reset value; an entry must be spawned before it is updated.
`default_nettype none
module particle_emitter_update_core #(
  parameter int PARTICLE_COUNT = pemu_pkg::DEFAULT_PARTICLE_COUNT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_addr,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pemu_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pemu_pkg::out_word_t      out_word
);
  pemu_pkg::cmd_t    cmd;
  pemu_pkg::status_t status;

  pemu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pemu_dp #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // a result is never written over one that is still waiting
  a_wb_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == pemu_pkg::CMD_WB |-> status.out_free)
    else $error("write-back while result register held");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == pemu_pkg::CMD_DSTART |-> !status.div_busy)
    else $error("divider started while busy");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.op == pemu_pkg::CMD_READ)
    else $error("accepted word not followed by table read");
endmodule
`default_nettype wire
